>>> rtl/apcc_pkg.sv
// package: shared constants, lane control struct and the 64-bit popcount function
package apcc_pkg;

    // default word width and the fixed widths of the counts
    localparam int WORD_BITS_DEF = 64;
    localparam int POP_W         = 7;
    localparam int CNT_W         = 32;
    localparam int GENOTYPES     = 3;

    // per-beat control handed from the top level to each counting lane
    typedef struct packed {
        logic adv;
        logic last;
    } t_lane_ctrl;

    // set-bit count of a 64-bit word as a six-level adder tree
    function automatic logic [POP_W-1:0] popcount64(input logic [63:0] v);
        logic [63:0] l1;
        logic [63:0] l2;
        logic [63:0] l3;
        logic [63:0] l4;
        logic [63:0] l5;
        logic [63:0] l6;
        l1 = (v  & 64'h5555_5555_5555_5555) + ((v  >> 1)  & 64'h5555_5555_5555_5555);
        l2 = (l1 & 64'h3333_3333_3333_3333) + ((l1 >> 2)  & 64'h3333_3333_3333_3333);
        l3 = (l2 & 64'h0F0F_0F0F_0F0F_0F0F) + ((l2 >> 4)  & 64'h0F0F_0F0F_0F0F_0F0F);
        l4 = (l3 & 64'h00FF_00FF_00FF_00FF) + ((l3 >> 8)  & 64'h00FF_00FF_00FF_00FF);
        l5 = (l4 & 64'h0000_FFFF_0000_FFFF) + ((l4 >> 16) & 64'h0000_FFFF_0000_FFFF);
        l6 = (l5 & 64'h0000_0000_FFFF_FFFF) + ((l5 >> 32) & 64'h0000_0000_FFFF_FFFF);
        return l6[POP_W-1:0];
    endfunction

endpackage

>>> rtl/apcc_in_if.sv
// interface: input channel carrying one word of each bitset row per beat
interface apcc_in_if #(
    parameter int WORD_BITS = apcc_pkg::WORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] first_word;
    logic [WORD_BITS-1:0] second_word0;
    logic [WORD_BITS-1:0] second_word1;
    logic [WORD_BITS-1:0] second_word2;
    logic                 last_word;
    logic                 last_row;

    modport source (
        output valid, first_word, second_word0, second_word1, second_word2,
               last_word, last_row,
        input  ready
    );

    modport sink (
        input  valid, first_word, second_word0, second_word1, second_word2,
               last_word, last_row,
        output ready
    );
endinterface

>>> rtl/apcc_out_if.sv
// interface: result channel carrying the three row counts per beat
interface apcc_out_if;
    logic                       valid;
    logic                       ready;
    logic [apcc_pkg::CNT_W-1:0] count0;
    logic [apcc_pkg::CNT_W-1:0] count1;
    logic [apcc_pkg::CNT_W-1:0] count2;
    logic                       row_done_last;

    modport source (
        output valid, count0, count1, count2, row_done_last,
        input  ready
    );

    modport sink (
        input  valid, count0, count1, count2, row_done_last,
        output ready
    );
endinterface

>>> rtl/apcc_lane.sv
// module: one genotype lane, and + popcount + wrapping running count
module apcc_lane #(
    parameter int WORD_BITS = apcc_pkg::WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  apcc_pkg::t_lane_ctrl       i_ctrl,
    input  logic [WORD_BITS-1:0]       i_a,
    input  logic [WORD_BITS-1:0]       i_b,
    output logic [apcc_pkg::CNT_W-1:0] o_sum
);
    import apcc_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [63:0]      and_w;
    logic [POP_W-1:0] pop;

    // and the two words, zero-extended to 64 bits for the popcount
    always_comb begin
        and_w                = '0;
        and_w[WORD_BITS-1:0] = i_a & i_b;
        pop                  = popcount64(and_w);
    end

    // running total including this beat, wraps modulo 2^32
    assign o_sum = r_cnt + CNT_W'(pop);

    // clear at the end of a row, add a middle word's count, otherwise keep the total
    always_comb begin
        n_cnt = r_cnt;
        if (i_ctrl.adv) begin
            n_cnt = i_ctrl.last ? '0 : o_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // count is empty right after a row has closed
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.adv && i_ctrl.last |=> r_cnt == '0)
        else $error("lane count not cleared after last word");

    // a middle word adds its count to the total
    a_middle_adds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.adv && !i_ctrl.last |=> r_cnt == $past(o_sum))
        else $error("lane count did not take a middle word");

    // a stalled lane keeps its count
    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.adv |=> $stable(r_cnt))
        else $error("lane count changed without a beat");

endmodule

>>> rtl/and_popcount_contingency_counter.sv
// top level: and-popcount contingency counter with input and result registers
//
// channel  dir  payload                                          beat
// i_in     in   first_word, second_word0..2, last_word, last_row  one word per row
// o_out    out  count0, count1, count2, row_done_last             one per row end
//
// takes one beat per cycle while no last word is held; a result goes from its
// last word through the input register, then the result register around the lanes
// reset (synchronous, active low) empties both registers and zeroes the counts
// a full result register that is not taken stalls only a last-word beat in the
// input register; middle words keep flowing into the running counts
module and_popcount_contingency_counter #(
    parameter int WORD_BITS = apcc_pkg::WORD_BITS_DEF
) (
    input logic  i_clk,
    input logic  i_rst_n,
    apcc_in_if.sink    i_in,
    apcc_out_if.source o_out
);
    import apcc_pkg::*;

    // input register
    logic                 r_s1_valid;
    logic [WORD_BITS-1:0] r_first;
    logic [WORD_BITS-1:0] r_second [GENOTYPES];
    logic                 r_s1_last;
    logic                 r_s1_last_row;

    // result register
    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_count [GENOTYPES];
    logic                 r_row_done_last;

    logic                 adv;
    logic                 load_out;
    logic                 in_take;
    t_lane_ctrl           lane_ctrl;
    logic [CNT_W-1:0]     lane_sum [GENOTYPES];

    // stage advance: a middle word always moves, a last word needs a free result slot
    assign adv      = r_s1_valid && (!r_s1_last || !r_out_valid || o_out.ready);
    assign load_out = adv && r_s1_last;
    assign i_in.ready = !r_s1_valid || adv;
    assign in_take  = i_in.valid && i_in.ready;

    assign lane_ctrl.adv  = adv;
    assign lane_ctrl.last = r_s1_last;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_first       <= i_in.first_word;
            r_second[0]   <= i_in.second_word0;
            r_second[1]   <= i_in.second_word1;
            r_second[2]   <= i_in.second_word2;
            r_s1_last     <= i_in.last_word;
            r_s1_last_row <= i_in.last_row;
        end
    end

    // one counting lane per genotype
    for (genvar g = 0; g < GENOTYPES; g++) begin : g_lane
        apcc_lane #(
            .WORD_BITS (WORD_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (lane_ctrl),
            .i_a     (r_first),
            .i_b     (r_second[g]),
            .o_sum   (lane_sum[g])
        );
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_count         <= lane_sum;
            r_row_done_last <= r_s1_last_row;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.count0        = r_count[0];
    assign o_out.count1        = r_count[1];
    assign o_out.count2        = r_count[2];
    assign o_out.row_done_last = r_row_done_last;

    // a closed row shows up as a result in the next cycle
    a_row_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_out.valid)
        else $error("row end did not produce a result");

    // a blocked last word backs up the input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready && r_s1_valid && r_s1_last |-> !i_in.ready)
        else $error("input taken while last word is blocked");

    // a middle word never waits for the result side
    a_middle_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_s1_last |-> i_in.ready)
        else $error("middle word stalled");

endmodule
